>>> rtl/ecq_pkg.sv
// ecq_pkg: types, constants and function codes for the error coalescing queue
// no dependencies
package ecq_pkg;

	localparam int IN_DEPTH_DEF   = 16;
	localparam int MAIN_DEPTH_DEF = 16;
	localparam int NUM_LEVELS     = 3;
	localparam int BOARD_SHIFT    = 16;
	localparam int COUNT_SHIFT    = 22;
	localparam logic [9:0] COUNT_MAX = 10'd1023;

	localparam logic [1:0] FUNC_RECORD = 2'd0;
	localparam logic [1:0] FUNC_DRAIN  = 2'd1;
	localparam logic [1:0] FUNC_POP    = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  source_level;
		logic [15:0] err_code;
		logic [31:0] time_now;
	} ecq_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] frame_word;
		logic [31:0] frame_time;
	} ecq_out_t;

endpackage

>>> rtl/error_coalescing_queue_top.sv
// error_coalescing_queue_top: three input rings and a coalescing ring held in
// synchronous memories with a registered read, walked by a small sequencer
// depends on ecq_pkg
//
// steps: a record writes its input ring; a pop reads the coalescing ring tail (an empty ring
// goes straight to the done state); a drain moves each code and compares it with each entry, a match ends the search.
// throughput: one word at a time; busy stays high until the result strobe.
// reset: all ring pointers and the board number clear; ring memories are not cleared
// (only written slots are ever used). the receiver cannot stall; result is shown
// for one cycle with done.
module error_coalescing_queue_top #(
	parameter int IN_DEPTH   = ecq_pkg::IN_DEPTH_DEF,
	parameter int MAIN_DEPTH = ecq_pkg::MAIN_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ecq_pkg::ecq_in_t cmd,
	output logic             done,
	output ecq_pkg::ecq_out_t result,
	input  logic             cfg_we,
	input  logic [5:0]       cfg_wdata
);
	import ecq_pkg::*;

	localparam int IW = $clog2(IN_DEPTH);
	localparam int MW = $clog2(MAIN_DEPTH);
	localparam int LW = $clog2(NUM_LEVELS * IN_DEPTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_POPRD = 3'd1;  // coalescing ring tail read in flight
	localparam logic [2:0] S_LVL   = 3'd2;  // pick next input level / slot
	localparam logic [2:0] S_INRD  = 3'd3;  // input ring read in flight
	localparam logic [2:0] S_SRCH  = 3'd4;  // issue compare read, or append when the search finds no match
	localparam logic [2:0] S_CMP   = 3'd5;  // compare read data
	localparam logic [2:0] S_DONE  = 3'd6;

	// input rings share one memory, addressed by level and slot
	logic [15:0] in_mem [NUM_LEVELS*IN_DEPTH];
	logic [15:0] in_rd_q;
	logic [15:0] code_mem [MAIN_DEPTH];
	logic [31:0] time_mem [MAIN_DEPTH];
	logic [9:0]  cnt_mem  [MAIN_DEPTH];
	logic [15:0] code_rd_q;
	logic [31:0] time_rd_q;
	logic [9:0]  cnt_rd_q;

	logic [IW-1:0] head_q [NUM_LEVELS];
	logic [IW-1:0] tail_q [NUM_LEVELS];
	logic [MW-1:0] mhead_q, mtail_q, idx_q;
	logic [5:0]    board_q;
	logic [2:0]    state_q;
	logic [1:0]    lvl_q;
	logic [31:0]   now_q;
	logic [15:0]   code_q;
	ecq_out_t      res_q;
	logic          done_q;

	// memory port controls
	logic          in_we, in_re, m_we, m_re, m_cnt_only;
	logic [LW-1:0] in_waddr, in_raddr;
	logic [15:0]   in_wdata;
	logic [MW-1:0] m_waddr, m_raddr;
	logic [9:0]    m_wcnt;

	function automatic logic [IW-1:0] in_nx(input logic [IW-1:0] i);
		return (32'(i) + 1 >= IN_DEPTH) ? '0 : i + 1'b1;
	endfunction
	function automatic logic [MW-1:0] m_nx(input logic [MW-1:0] i);
		return (32'(i) + 1 >= MAIN_DEPTH) ? '0 : i + 1'b1;
	endfunction
	function automatic logic [LW-1:0] in_addr(input logic [1:0] l, input logic [IW-1:0] s);
		return LW'(32'(l) * IN_DEPTH + 32'(s));
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk) begin
		if (in_we) in_mem[in_waddr] <= in_wdata;
		if (in_re) in_rd_q <= in_mem[in_raddr];
		if (m_we) begin
			cnt_mem[m_waddr] <= m_wcnt;
			if (!m_cnt_only) begin
				code_mem[m_waddr] <= code_q;
				time_mem[m_waddr] <= now_q;
			end
		end
		if (m_re) begin
			code_rd_q <= code_mem[m_raddr];
			time_rd_q <= time_mem[m_raddr];
			cnt_rd_q  <= cnt_mem[m_raddr];
		end
	end

	// sequencer: control decisions made combinationally, applied in one block
	always_comb begin
		in_we = 1'b0; in_re = 1'b0; m_we = 1'b0; m_re = 1'b0; m_cnt_only = 1'b0;
		in_waddr = in_addr(cmd.source_level, head_q[cmd.source_level[1] ? 2 : cmd.source_level[0] ? 1 : 0]);
		in_wdata = cmd.err_code;
		in_raddr = in_addr(lvl_q, tail_q[lvl_q[1] ? 2 : lvl_q[0] ? 1 : 0]);
		m_waddr  = mhead_q;
		m_raddr  = idx_q;
		m_wcnt   = 10'd1;
		if (state_q == S_IDLE && start && cmd.func == FUNC_RECORD && cmd.source_level != 2'd3) begin
			if (in_nx(head_q[cmd.source_level[1] ? 2 : cmd.source_level[0] ? 1 : 0]) !=
			    tail_q[cmd.source_level[1] ? 2 : cmd.source_level[0] ? 1 : 0])
				in_we = 1'b1;
		end
		if (state_q == S_IDLE && start && cmd.func == FUNC_POP) begin
			m_re = 1'b1;
			m_raddr = mtail_q;
		end
		if (state_q == S_LVL && lvl_q != 2'd3) in_re = 1'b1;
		if (state_q == S_SRCH && idx_q != mhead_q) m_re = 1'b1;
		if (state_q == S_SRCH && idx_q == mhead_q && m_nx(mhead_q) != mtail_q) m_we = 1'b1;
		if (state_q == S_CMP && code_rd_q == code_q) begin
			m_we = 1'b1; m_cnt_only = 1'b1; m_waddr = idx_q;
			m_wcnt = (cnt_rd_q < COUNT_MAX) ? cnt_rd_q + 10'd1 : cnt_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			mhead_q <= '0;
			mtail_q <= '0;
			board_q <= '0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_we) board_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						res_q   <= '0;
						now_q   <= cmd.time_now;
						lvl_q   <= '0;
						case (cmd.func)
							FUNC_RECORD: begin
								state_q <= S_DONE;
								if (cmd.source_level != 2'd3) begin
									if (in_we)
										head_q[cmd.source_level[1] ? 2 : cmd.source_level[0] ? 1 : 0]
											<= in_nx(head_q[cmd.source_level[1] ? 2 : cmd.source_level[0] ? 1 : 0]);
									else
										res_q.status <= ST_FULL;
								end
							end
							FUNC_DRAIN: state_q <= S_LVL;
							FUNC_POP: begin
								if (mtail_q == mhead_q) begin
									res_q.status <= ST_EMPTY;
									state_q <= S_DONE;
								end else state_q <= S_POPRD;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_POPRD: begin
					res_q.frame_word <= {cnt_rd_q, board_q, code_rd_q};
					res_q.frame_time <= time_rd_q;
					mtail_q <= m_nx(mtail_q);
					state_q <= S_DONE;
				end
				S_LVL: begin
					// skip empty levels; read issued for any real level, used only if not empty
					if (lvl_q == 2'd3) state_q <= S_DONE;
					else if (tail_q[lvl_q[1] ? 2 : lvl_q[0] ? 1 : 0] ==
					         head_q[lvl_q[1] ? 2 : lvl_q[0] ? 1 : 0]) begin
						lvl_q <= (lvl_q == 2'd2) ? 2'd3 : lvl_q + 2'd1;
					end else begin
						tail_q[lvl_q[1] ? 2 : lvl_q[0] ? 1 : 0]
							<= in_nx(tail_q[lvl_q[1] ? 2 : lvl_q[0] ? 1 : 0]);
						state_q <= S_INRD;
					end
				end
				S_INRD: begin
					code_q  <= in_rd_q;
					idx_q   <= mtail_q;
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (idx_q != mhead_q) state_q <= S_CMP;
					else begin
						if (m_we) mhead_q <= m_nx(mhead_q);
						state_q <= S_LVL;
					end
				end
				S_CMP: begin
					if (code_rd_q == code_q) state_q <= S_LVL;
					else begin
						idx_q   <= m_nx(idx_q);
						state_q <= S_SRCH;
					end
				end
				S_DONE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> dv/error_coalescing_queue_top_test.sv
// error_coalescing_queue_top_test: self-checking bench for the error coalescing queue
// drives record, drain and pop words, predicts every result in-line; needs ecq_pkg and the rtl
`timescale 1ns / 100ps

module error_coalescing_queue_top_test;
	import ecq_pkg::*;

	localparam int RAND_ITEMS = 150;
	localparam int CYCLE_LIMIT = 10000000;
	localparam int DEPTH = 16;
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam logic [1:0] LVL_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	ecq_in_t cmd = '0;
	logic done;
	ecq_out_t result;
	logic cfg_we = 1'b0;
	logic [5:0] cfg_wdata = '0;

	error_coalescing_queue_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// queue model: three input rings feeding one coalescing ring
	// ------------------------------------------------------------------
	logic [15:0] lvl_ring [3][DEPTH];
	int lvl_head [3];
	int lvl_tail [3];
	logic [15:0] ent_code [DEPTH];
	logic [31:0] ent_time [DEPTH];
	logic [9:0] ent_count [DEPTH];
	int ent_head, ent_tail;
	logic [5:0] board_m;

	// coverage-style tallies for the closing summary
	int n_dropped_rec, n_dropped_ent, n_saturated, n_empty_pop, n_frames, n_merged;

	ecq_out_t pending_frames[$];
	int mismatches, cycles;

	function automatic int wrap(int i);
		return (i + 1 >= DEPTH) ? 0 : i + 1;
	endfunction

	function automatic void merge_code(logic [15:0] code, logic [31:0] now);
		int i;
		i = ent_tail;
		while (i != ent_head) begin
			if (ent_code[i] == code) begin
				if (ent_count[i] < COUNT_MAX) ent_count[i]++;
				else n_saturated++;
				n_merged++;
				return;
			end
			i = wrap(i);
		end
		if (wrap(ent_head) == ent_tail) begin
			n_dropped_ent++;
			return;
		end
		ent_code[ent_head] = code;
		ent_time[ent_head] = now;
		ent_count[ent_head] = 10'd1;
		ent_head = wrap(ent_head);
	endfunction

	function automatic ecq_out_t step_queue_model(ecq_in_t c);
		ecq_out_t r;
		int t;
		r = '0;
		r.status = ST_OK;
		case (c.func)
			FUNC_RECORD: begin
				if (c.source_level != LVL_NONE) begin
					if (wrap(lvl_head[c.source_level]) == lvl_tail[c.source_level]) begin
						r.status = ST_FULL;
						n_dropped_rec++;
					end else begin
						lvl_ring[c.source_level][lvl_head[c.source_level]] = c.err_code;
						lvl_head[c.source_level] = wrap(lvl_head[c.source_level]);
					end
				end
			end
			FUNC_DRAIN: begin
				// normal first, then irq, then fiq
				for (int lv = 0; lv < NUM_LEVELS; lv++) begin
					t = lvl_tail[lv];
					while (t != lvl_head[lv]) begin
						merge_code(lvl_ring[lv][t], c.time_now);
						t = wrap(t);
					end
					lvl_tail[lv] = t;
				end
			end
			FUNC_POP: begin
				if (ent_tail == ent_head) begin
					r.status = ST_EMPTY;
					n_empty_pop++;
				end else begin
					r.frame_word = {ent_count[ent_tail], board_m, ent_code[ent_tail]};
					r.frame_time = ent_time[ent_tail];
					ent_tail = wrap(ent_tail);
					n_frames++;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// handshake sampling at the falling edge, away from the dut's updates
	// ------------------------------------------------------------------
	logic take_q = 1'b0;

	always @(negedge clk) begin
		ecq_out_t want;
		take_q = start && !busy;
		if (done) begin
			if (pending_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: status %0d word %h time %h",
						result.status, result.frame_word, result.frame_time);
			end else begin
				want = pending_frames.pop_front();
				if (result.status !== want.status || result.frame_word !== want.frame_word ||
						result.frame_time !== want.frame_time) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%h/%h got %0d/%h/%h", want.status,
							want.frame_word, want.frame_time, result.status,
							result.frame_word, result.frame_time);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed", cycles,
				pending_frames.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// driver helpers
	// ------------------------------------------------------------------

	// hands one word over and keeps start high; caller decides about gaps
	task automatic issue(ecq_in_t c, bit typed, ecq_out_t typed_res);
		ecq_out_t r;
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (!take_q);
		r = step_queue_model(c);
		pending_frames.push_back(typed ? typed_res : r);
	endtask

	task automatic drain_to_idle();
		start <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		// allow for any last internal bookkeeping before touching config
		repeat (4) @(posedge clk);
	endtask

	task automatic write_board(logic [5:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		board_m = v;
		cfg_we <= 1'b0;
	endtask

	function automatic ecq_in_t mk(logic [1:0] f, logic [1:0] lv, logic [15:0] code,
			logic [31:0] now);
		ecq_in_t c;
		c.func = f;
		c.source_level = lv;
		c.err_code = code;
		c.time_now = now;
		return c;
	endfunction

	function automatic ecq_out_t frame(logic [1:0] st, logic [31:0] w, logic [31:0] t);
		ecq_out_t r;
		r.status = st;
		r.frame_word = w;
		r.frame_time = t;
		return r;
	endfunction

	// directed table row: typed rows carry their own expected word
	typedef struct {
		ecq_in_t c;
		bit typed;
		ecq_out_t r;
	} dir_row_t;

	logic [15:0] code_pool [24];

	initial begin
		dir_row_t rows[$];
		ecq_in_t c;
		int burst, gap, roll, sent;
		logic [5:0] cfg_plan [5];
		logic [15:0] sat_code;

		for (int i = 0; i < NUM_LEVELS; i++) begin
			lvl_head[i] = 0;
			lvl_tail[i] = 0;
		end
		ent_head = 0;
		ent_tail = 0;
		board_m = '0;
		mismatches = 0;
		cycles = 0;
		for (int i = 0; i < 24; i++) code_pool[i] = 16'($urandom);
		cfg_plan = '{6'd0, 6'($urandom), 6'd63, 6'($urandom), 6'd21};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, board id at its top value ----
		write_board(6'd63);
		rows.push_back('{mk(FUNC_POP, 2'd0, 16'h0, 32'h0), 1'b1,
			frame(ST_EMPTY, 32'h0, 32'h0)});
		rows.push_back('{mk(FUNC_DRAIN, 2'd0, 16'h0, 32'h0), 1'b1,
			frame(ST_OK, 32'h0, 32'h0)});
		rows.push_back('{mk(FUNC_NOP, 2'd3, 16'hffff, 32'hffffffff), 1'b1,
			frame(ST_OK, 32'h0, 32'h0)});
		rows.push_back('{mk(FUNC_RECORD, LVL_NONE, 16'hbeef, 32'h0), 1'b1,
			frame(ST_OK, 32'h0, 32'h0)});
		rows.push_back('{mk(FUNC_RECORD, 2'd0, 16'hffff, 32'h0), 1'b1,
			frame(ST_OK, 32'h0, 32'h0)});
		rows.push_back('{mk(FUNC_RECORD, 2'd1, 16'h0000, 32'h0), 1'b1,
			frame(ST_OK, 32'h0, 32'h0)});
		rows.push_back('{mk(FUNC_RECORD, 2'd2, 16'h1234, 32'h0), 1'b1,
			frame(ST_OK, 32'h0, 32'h0)});
		rows.push_back('{mk(FUNC_RECORD, 2'd0, 16'hffff, 32'h0), 1'b1,
			frame(ST_OK, 32'h0, 32'h0)});
		rows.push_back('{mk(FUNC_DRAIN, 2'd0, 16'h0, 32'hffffffff), 1'b1,
			frame(ST_OK, 32'h0, 32'h0)});
		// duplicate ffff merged to count two, normal level popped first
		rows.push_back('{mk(FUNC_POP, 2'd0, 16'h0, 32'h0), 1'b1,
			frame(ST_OK, {10'd2, 6'd63, 16'hffff}, 32'hffffffff)});
		rows.push_back('{mk(FUNC_POP, 2'd0, 16'h0, 32'h0), 1'b1,
			frame(ST_OK, {10'd1, 6'd63, 16'h0000}, 32'hffffffff)});
		rows.push_back('{mk(FUNC_POP, 2'd0, 16'h0, 32'h0), 1'b1,
			frame(ST_OK, {10'd1, 6'd63, 16'h1234}, 32'hffffffff)});
		rows.push_back('{mk(FUNC_POP, 2'd0, 16'h0, 32'h0), 1'b1,
			frame(ST_EMPTY, 32'h0, 32'h0)});
		foreach (rows[i]) issue(rows[i].c, rows[i].typed, rows[i].r);

		// fill one input ring past capacity, then overflow the coalescing ring
		for (int i = 0; i < DEPTH; i++)
			issue(mk(FUNC_RECORD, 2'd2, 16'h5a00 + 16'(i), 32'h0), 1'b0, '0);
		issue(mk(FUNC_RECORD, 2'd0, 16'ha5ff, 32'h0), 1'b0, '0);
		issue(mk(FUNC_DRAIN, 2'd0, 16'h0, 32'h0000_0001), 1'b0, '0);
		drain_to_idle();

		// ---- saturation: one code driven past a count of 1023 ----
		for (int i = 0; i < DEPTH; i++) issue(mk(FUNC_POP, 2'd0, 16'h0, 32'h0), 1'b0, '0);
		sat_code = 16'($urandom);
		for (int rep = 0; rep < 24; rep++) begin
			for (int lv = 0; lv < NUM_LEVELS; lv++)
				for (int i = 0; i < DEPTH - 1; i++)
					issue(mk(FUNC_RECORD, 2'(lv), sat_code, 32'h0), 1'b0, '0);
			issue(mk(FUNC_DRAIN, 2'd0, 16'h0, $urandom), 1'b0, '0);
		end
		issue(mk(FUNC_POP, 2'd0, 16'h0, 32'h0), 1'b0, '0);

		// ---- random part, in phases with a board id change between them ----
		sent = 0;
		for (int ph = 0; ph < 5; ph++) begin
			drain_to_idle();
			write_board(cfg_plan[ph]);
			while (sent < (ph + 1) * RAND_ITEMS / 5) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst; b++) begin
					roll = $urandom_range(0, 99);
					c.func = (roll < 55) ? FUNC_RECORD : (roll < 70) ? FUNC_DRAIN :
						(roll < 96) ? FUNC_POP : FUNC_NOP;
					c.source_level = ($urandom_range(0, 19) == 0) ? LVL_NONE :
						2'($urandom_range(0, 2));
					c.err_code = ($urandom_range(0, 9) < 7) ?
						code_pool[$urandom_range(0, 23)] : 16'($urandom);
					c.time_now = $urandom;
					issue(c, 1'b0, '0);
					sent++;
				end
				// gaps between bursts, sometimes none at all
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				// now and then hold off until the queue has answered everything
				if ($urandom_range(0, 29) == 0) drain_to_idle();
			end
		end

		start <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d frames, %0d empty pops, %0d merges (%0d at the count ceiling)",
			n_frames, n_empty_pop, n_merged, n_saturated);
		$display("dropped %0d records on full input rings, %0d entries on a full main ring",
			n_dropped_rec, n_dropped_ent);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> error_coalescing_queue_top.f
rtl/ecq_pkg.sv
rtl/error_coalescing_queue_top.sv
dv/error_coalescing_queue_top_test.sv
